@@ design/ema_ot_pkg.sv @@
// Shared constants, types and elaboration-time functions of the occupancy threshold adjuster.
`timescale 1ns / 1ps

package ema_ot_pkg;

   // Field widths
   localparam int CNT_W      = 16;
   localparam int CAP_W      = 16;
   localparam int THR_W      = 32;
   localparam int AVG_W      = 23;
   localparam int FAC_W      = 17;
   localparam int TAB_W      = 17;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // Internal datapath widths
   localparam int SUM_W   = 26;
   localparam int TVX_W   = 18;
   localparam int BOOST_W = 21;
   localparam int PROD_W  = THR_W + FAC_W;
   localparam int RND_W   = 33;

   localparam int TANH_DEPTH_DEF = 64;

   // Percent levels in Q7.16
   localparam logic [AVG_W-1:0] PCT_FULL  = 23'd6553600;
   localparam logic [AVG_W-1:0] PCT_70    = 23'd4587520;
   localparam logic [AVG_W-1:0] PCT_85    = 23'd5570560;
   localparam logic [AVG_W-1:0] PCT_95    = 23'd6225920;
   localparam logic [AVG_W-1:0] TREND_SAT = 23'd2621440;

   // Factors in Q16
   localparam logic [FAC_W-1:0] FAC_ONE  = 17'd65536;
   localparam logic [FAC_W-1:0] FAC_FALL = 17'd58982;

   // Reset values of registers and state
   localparam logic [CAP_W-1:0] CAP_RESET   = 16'd1024;
   localparam logic [THR_W-1:0] START_RESET = 32'd65536;
   localparam logic [THR_W-1:0] MIN_RESET   = 32'd0;
   localparam logic [THR_W-1:0] MAX_RESET   = 32'hFFFF_FFFF;
   localparam logic [THR_W-1:0] THR_RESET   = 32'd65536;

   // Reciprocal of five at 2^34 and of ten at 2^35, exact for 32-bit operands
   localparam logic [63:0] RECIP_TEN = 64'h0000_0000_CCCC_CCCD;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STORE_CAPACITY  = 8'd0,
      CSR_START_THRESHOLD = 8'd1,
      CSR_MIN_THRESHOLD   = 8'd2,
      CSR_MAX_THRESHOLD   = 8'd3
   } csr_index_type;

   typedef enum logic {
      OP_UPDATE  = 1'b0,
      OP_RESTART = 1'b1
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIV,
      ST_SUM,
      ST_AVG,
      ST_TREND,
      ST_SCALE,
      ST_POS,
      ST_TAB,
      ST_INTERP,
      ST_FAC,
      ST_BOOST,
      ST_BDIV,
      ST_MSTART,
      ST_MUL,
      ST_ROUND,
      ST_CLAMP,
      ST_OUT
   } state_type;

   // Divide by ten through the reciprocal
   function automatic logic [28:0] div10(input logic [31:0] x);
      logic [63:0] p;
      p = {32'd0, x} * RECIP_TEN;
      return p[63:35];
   endfunction

   // Divide by five through the reciprocal
   function automatic logic [29:0] div5(input logic [31:0] x);
      logic [63:0] p;
      p = {32'd0, x} * RECIP_TEN;
      return p[63:34];
   endfunction

   // Long division by shift and subtract, for table construction only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      int          k;
      q = '0;
      r = '0;
      for (k = 63; k >= 0; k--) begin
         r = {r[62:0], num[k]};
         if (r >= den) begin
            r    = r - den;
            q[k] = 1'b1;
         end
      end
      return q;
   endfunction

   // One tanh table entry in Q16: tanh(4*idx/depth) by the addition formula in Q30
   function automatic logic [TAB_W-1:0] tanh_entry(input int depth, input int idx);
      logic [63:0] h;
      logic [63:0] h2;
      logic [63:0] h3;
      logic [63:0] h5;
      logic [63:0] h7;
      logic [63:0] th;
      logic [63:0] t;
      logic [63:0] q30;
      int          k;
      q30 = 64'd1 << 30;
      h   = udiv64(64'd1 << 32, 64'(depth));
      h2  = (h * h) >> 30;
      h3  = (h2 * h) >> 30;
      h5  = (h3 * h2) >> 30;
      h7  = (h5 * h2) >> 30;
      th  = h - h3 / 64'd3 + (64'd2 * h5) / 64'd15 - (64'd17 * h7) / 64'd315;
      t   = '0;
      for (k = 0; k < idx; k++) begin
         t = udiv64((t + th) << 30, q30 + ((t * th) >> 30));
      end
      return TAB_W'((t + 64'd8192) >> 14);
   endfunction

endpackage

@@ design/ema_ot_if.sv @@
// Request, response and register write channel interfaces of the threshold adjuster.
`timescale 1ns / 1ps

interface ema_ot_req_if import ema_ot_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             operation;
   logic [CNT_W-1:0] entry_count;

   modport source (output valid, output operation, output entry_count, input ready);
   modport sink   (input valid, input operation, input entry_count, output ready);
endinterface

interface ema_ot_rsp_if import ema_ot_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [THR_W-1:0] threshold_value;
   logic [AVG_W-1:0] average_occupancy;
   logic             pressure_rising;

   modport source (output valid, output threshold_value, output average_occupancy,
                   output pressure_rising, input ready);
   modport sink   (input valid, input threshold_value, input average_occupancy,
                   input pressure_rising, output ready);
endinterface

interface ema_ot_csr_if import ema_ot_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/ema_ot_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module ema_ot_div import ema_ot_pkg::*; #(
   parameter int DIVISOR_W = CAP_W,
   parameter int QUOT_W    = AVG_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIVISOR_W-1:0] divisor,
   input  logic [DIVISOR_W-1:0] rem_init,
   input  logic [QUOT_W-1:0]    dividend,
   output logic                 done,
   output logic [QUOT_W-1:0]    quotient
);

   localparam int STEP_W = $clog2(QUOT_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;

   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   // Bring down the next dividend bit and try the subtraction
   assign trial = {rem_ff, quot_ff[QUOT_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = STEP_W'(QUOT_W);
         divisor_in = divisor;
         rem_in     = rem_init;
         quot_in    = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

@@ design/ema_ot_mul.sv @@
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps

module ema_ot_mul import ema_ot_pkg::*; #(
   parameter int A_W = THR_W,
   parameter int B_W = FAC_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               done,
   output logic [A_W+B_W-1:0] product
);

   localparam int P_W    = A_W + B_W;
   localparam int STEP_W = $clog2(B_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [A_W-1:0]    a_ff, a_in;
   logic [B_W-1:0]    b_ff, b_in;
   logic [P_W-1:0]    acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(B_W);
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         // Double the partial sum and add the multiplicand under the top bit
         acc_in  = {acc_ff[P_W-2:0], 1'b0} + (b_ff[B_W-1] ? P_W'(a_ff) : '0);
         b_in    = {b_ff[B_W-2:0], 1'b0};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ design/ema_occupancy_threshold_adjust.sv @@
// Top level: occupancy moving average and threshold adjustment sequencer.
// An update whose average rises also runs the tanh lookup states, and every update waits on the
// bit-serial occupancy divider and the bit-serial threshold multiplier; the other sequencer steps
// are states of their own. A restart goes straight from idle to the output state.
// One request is worked at a time; ready returns in the same cycle as the result appears in the
// output register, and a response stall holds the block in its output state until that register frees.
// Reset is synchronous: registers take their defaults, the average clears, the threshold is 1.0.
`timescale 1ns / 1ps

module ema_occupancy_threshold_adjust import ema_ot_pkg::*; #(
   parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ema_ot_req_if.sink   req_chan,
   ema_ot_rsp_if.source rsp_chan,
   ema_ot_csr_if.sink   csr_chan
);

   localparam int TW = $clog2(TANH_TABLE_DEPTH + 1);

   // Tanh table, built at elaboration
   logic [TAB_W-1:0] tanh_rom [TANH_TABLE_DEPTH+1];

   for (genvar gi = 0; gi <= TANH_TABLE_DEPTH; gi++) begin : g_tanh
      localparam logic [TAB_W-1:0] ENTRY = tanh_entry(TANH_TABLE_DEPTH, gi);
      assign tanh_rom[gi] = ENTRY;
   end

   state_type        state_ff, state_in;

   // Configuration registers
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [THR_W-1:0] start_ff, start_in;
   logic [THR_W-1:0] min_ff, min_in;
   logic [THR_W-1:0] max_ff, max_in;

   // Block state
   logic [AVG_W-1:0] avg_ff, avg_in;
   logic [THR_W-1:0] thr_ff, thr_in;

   // Working registers
   logic               sat_ff, sat_in;
   logic [SUM_W-1:0]   x_ff, x_in;
   logic [AVG_W-1:0]   newavg_ff, newavg_in;
   logic               rise_ff, rise_in;
   logic               fall_ff, fall_in;
   logic [AVG_W-1:0]   trend_ff, trend_in;
   logic               tsat_ff, tsat_in;
   logic [31:0]        y_ff, y_in;
   logic [TW-1:0]      idx_ff, idx_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [TAB_W-1:0]   a_ff, a_in;
   logic [TAB_W-1:0]   diff_ff, diff_in;
   logic               neg_ff, neg_in;
   logic [TAB_W-1:0]   tv_ff, tv_in;
   logic [FAC_W-1:0]   fac_ff, fac_in;
   logic [BOOST_W-1:0] xb_ff, xb_in;
   logic [RND_W-1:0]   r_ff, r_in;
   logic [THR_W-1:0]   res_thr_ff, res_thr_in;
   logic [AVG_W-1:0]   res_avg_ff, res_avg_in;
   logic               res_rise_ff, res_rise_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [THR_W-1:0]   rsp_thr_ff, rsp_thr_in;
   logic [AVG_W-1:0]   rsp_avg_ff, rsp_avg_in;
   logic               rsp_rise_ff, rsp_rise_in;

   // Datapath helpers
   logic               req_accept;
   logic [CAP_W-1:0]   cap_eff;
   logic [AVG_W-1:0]   count100;
   logic               div_start;
   logic               div_done;
   logic [AVG_W-1:0]   div_quot;
   logic               mul_start;
   logic               mul_done;
   logic [PROD_W-1:0]  mul_prod;
   logic [AVG_W-1:0]   occ;
   logic [29:0]        pos;
   logic [TW-1:0]      idx_next;
   logic [TAB_W-1:0]   tab_a;
   logic [TAB_W-1:0]   tab_b;
   logic [RND_W-1:0]   interp_prod;
   logic [TAB_W-1:0]   interp_step;
   logic [TVX_W-1:0]   fac_x;
   logic [THR_W-1:0]   clamp_hi;
   logic [THR_W-1:0]   clamp_lo;

   assign req_chan.ready = state_ff == ST_IDLE;
   assign csr_chan.ready = 1'b1;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Occupancy division: count*100*65536 / capacity, quotient below 2^23 when unsaturated
   assign cap_eff   = (cap_ff == '0) ? CAP_W'(1) : cap_ff;
   assign count100  = AVG_W'(req_chan.entry_count) * AVG_W'(100);
   assign div_start = req_accept && (req_chan.operation == OP_UPDATE);
   assign mul_start = state_ff == ST_MSTART;

   ema_ot_div #(
      .DIVISOR_W (CAP_W),
      .QUOT_W    (AVG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (cap_eff),
      .rem_init (count100[22:7]),
      .dividend ({count100[6:0], 16'd0}),
      .done     (div_done),
      .quotient (div_quot)
   );

   ema_ot_mul #(
      .A_W (THR_W),
      .B_W (FAC_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (thr_ff),
      .b       (fac_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign occ = sat_ff ? PCT_FULL : div_quot;

   // Table position: trend*depth/40 as (trend*depth/8)/5
   assign pos      = div5(y_ff >> 3);
   assign idx_next = (idx_ff == TW'(TANH_TABLE_DEPTH)) ? idx_ff : idx_ff + TW'(1);
   assign tab_a    = tanh_rom[idx_ff];
   assign tab_b    = tanh_rom[idx_next];

   // Linear interpolation between neighboring entries
   assign interp_prod = RND_W'(diff_ff) * RND_W'(frac_ff);
   assign interp_step = interp_prod[32:16];

   // Rising factor numerator: doubled tanh above 70 percent
   assign fac_x = (newavg_ff > PCT_70) ? ({tv_ff, 1'b0} + TVX_W'(5))
                                       : ({1'b0, tv_ff} + TVX_W'(5));

   // Clamp to max first, then min
   assign clamp_hi = (r_ff > {1'b0, max_ff}) ? max_ff : r_ff[THR_W-1:0];
   assign clamp_lo = (clamp_hi < min_ff) ? min_ff : clamp_hi;

   // Register writes
   always_comb begin
      cap_in   = cap_ff;
      start_in = start_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_STORE_CAPACITY:  cap_in   = csr_chan.data[CAP_W-1:0];
            CSR_START_THRESHOLD: start_in = csr_chan.data;
            CSR_MIN_THRESHOLD:   min_in   = csr_chan.data;
            CSR_MAX_THRESHOLD:   max_in   = csr_chan.data;
            default: ;
         endcase
      end
   end

   // Sequencer: next state and datapath loads
   always_comb begin
      state_in     = state_ff;
      avg_in       = avg_ff;
      thr_in       = thr_ff;
      sat_in       = sat_ff;
      x_in         = x_ff;
      newavg_in    = newavg_ff;
      rise_in      = rise_ff;
      fall_in      = fall_ff;
      trend_in     = trend_ff;
      tsat_in      = tsat_ff;
      y_in         = y_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      a_in         = a_ff;
      diff_in      = diff_ff;
      neg_in       = neg_ff;
      tv_in        = tv_ff;
      fac_in       = fac_ff;
      xb_in        = xb_ff;
      r_in         = r_ff;
      res_thr_in   = res_thr_ff;
      res_avg_in   = res_avg_ff;
      res_rise_in  = res_rise_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_thr_in   = rsp_thr_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_rise_in  = rsp_rise_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.operation == OP_RESTART) begin
                  // Reload the start threshold and clear the average
                  thr_in      = start_ff;
                  avg_in      = '0;
                  res_thr_in  = start_ff;
                  res_avg_in  = '0;
                  res_rise_in = 1'b0;
                  state_in    = ST_OUT;
               end else begin
                  sat_in   = req_chan.entry_count >= cap_eff;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            x_in     = SUM_W'(occ) + (SUM_W'(avg_ff) << 3) + SUM_W'(avg_ff) + SUM_W'(5);
            state_in = ST_AVG;
         end
         ST_AVG: begin
            newavg_in = AVG_W'(div10(32'(x_ff)));
            state_in  = ST_TREND;
         end
         ST_TREND: begin
            rise_in  = newavg_ff > avg_ff;
            fall_in  = newavg_ff < avg_ff;
            trend_in = newavg_ff - avg_ff;
            state_in = (newavg_ff > avg_ff) ? ST_SCALE : ST_FAC;
         end
         ST_SCALE: begin
            tsat_in  = trend_ff >= TREND_SAT;
            y_in     = 32'(trend_ff) * 32'(TANH_TABLE_DEPTH);
            state_in = ST_POS;
         end
         ST_POS: begin
            // Trend beyond the table takes the last entry
            if (tsat_ff) begin
               idx_in  = TW'(TANH_TABLE_DEPTH);
               frac_in = '0;
            end else begin
               idx_in  = TW'(pos >> 16);
               frac_in = pos[FRAC_W-1:0];
            end
            state_in = ST_TAB;
         end
         ST_TAB: begin
            a_in     = tab_a;
            neg_in   = tab_b < tab_a;
            diff_in  = (tab_b < tab_a) ? tab_a - tab_b : tab_b - tab_a;
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            tv_in    = neg_ff ? a_ff - interp_step : a_ff + interp_step;
            state_in = ST_FAC;
         end
         ST_FAC: begin
            if (rise_ff) begin
               fac_in = FAC_ONE + FAC_W'(div10(32'(fac_x)));
            end else if (fall_ff) begin
               fac_in = FAC_FALL;
            end else begin
               fac_in = FAC_ONE;
            end
            state_in = ST_BOOST;
         end
         ST_BOOST: begin
            // High average boosts the factor; otherwise pass it through times ten
            if (newavg_ff > PCT_95) begin
               xb_in = BOOST_W'(fac_ff) * BOOST_W'(13) + BOOST_W'(5);
            end else if (newavg_ff > PCT_85) begin
               xb_in = BOOST_W'(fac_ff) * BOOST_W'(12) + BOOST_W'(5);
            end else begin
               xb_in = BOOST_W'(fac_ff) * BOOST_W'(10);
            end
            state_in = ST_BDIV;
         end
         ST_BDIV: begin
            fac_in   = FAC_W'(div10(32'(xb_ff)));
            state_in = ST_MSTART;
         end
         ST_MSTART: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            r_in     = RND_W'((mul_prod + PROD_W'(32768)) >> 16);
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            thr_in      = clamp_lo;
            avg_in      = newavg_ff;
            res_thr_in  = clamp_lo;
            res_avg_in  = newavg_ff;
            res_rise_in = rise_ff;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            // Hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_thr_in   = res_thr_ff;
               rsp_avg_in   = res_avg_ff;
               rsp_rise_in  = res_rise_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         start_ff     <= START_RESET;
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
         avg_ff       <= '0;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         start_ff     <= start_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         avg_ff       <= avg_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff      <= sat_in;
      x_ff        <= x_in;
      newavg_ff   <= newavg_in;
      rise_ff     <= rise_in;
      fall_ff     <= fall_in;
      trend_ff    <= trend_in;
      tsat_ff     <= tsat_in;
      y_ff        <= y_in;
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      a_ff        <= a_in;
      diff_ff     <= diff_in;
      neg_ff      <= neg_in;
      tv_ff       <= tv_in;
      fac_ff      <= fac_in;
      xb_ff       <= xb_in;
      r_ff        <= r_in;
      res_thr_ff  <= res_thr_in;
      res_avg_ff  <= res_avg_in;
      res_rise_ff <= res_rise_in;
      rsp_thr_ff  <= rsp_thr_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_rise_ff <= rsp_rise_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.threshold_value   = rsp_thr_ff;
   assign rsp_chan.average_occupancy = rsp_avg_ff;
   assign rsp_chan.pressure_rising   = rsp_rise_ff;

endmodule

@@ design/ema_ot_checker.sv @@
// Port-level checker for the threshold adjuster, bound to the top level.
`timescale 1ns / 1ps

module ema_ot_checker import ema_ot_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [THR_W-1:0] rsp_threshold_value,
   input logic [AVG_W-1:0] rsp_average_occupancy,
   input logic             rsp_pressure_rising
);

   // Hold a stalled response and its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_threshold_value) &&
         $stable(rsp_average_occupancy) && $stable(rsp_pressure_rising))
      else $error("stalled response changed");

   // Drop ready after accepting a request: one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // A rising average is never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressure_rising |-> rsp_average_occupancy != '0)
      else $error("rising pressure with zero average");

   // Average stays within one hundred percent
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_average_occupancy <= PCT_FULL)
      else $error("average above full occupancy");

   // No response in the first cycle after reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ema_occupancy_threshold_adjust ema_ot_checker u_ema_ot_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_chan.valid),
   .req_ready             (req_chan.ready),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .rsp_threshold_value   (rsp_chan.threshold_value),
   .rsp_average_occupancy (rsp_chan.average_occupancy),
   .rsp_pressure_rising   (rsp_chan.pressure_rising)
);

@@ dv/tb_ema_occupancy_threshold_adjust.sv @@
// Self-checking testbench for the occupancy threshold adjuster: predicts each result and compares.
`timescale 1ns / 1ps

module tb_ema_occupancy_threshold_adjust;
   import ema_ot_pkg::*;

   localparam int          TANH_DEPTH     = 64;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          SETTLE_CYCLES  = 70;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          MAX_REPORTS    = 40;
   localparam longint unsigned PCT_UNIT   = 65536;

   typedef struct packed {
      logic [THR_W-1:0] threshold_value;
      logic [AVG_W-1:0] average_occupancy;
      logic             pressure_rising;
   } threshold_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ema_ot_req_if req_if();
   ema_ot_rsp_if rsp_if();
   ema_ot_csr_if csr_if();

   ema_occupancy_threshold_adjust #(
      .TANH_TABLE_DEPTH(TANH_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   // Predictor state and register copy
   longint unsigned   tanh_q16 [0:TANH_DEPTH];
   logic [AVG_W-1:0]  avg_state = '0;
   logic [THR_W-1:0]  thr_state = 32'd65536;
   logic [CAP_W-1:0]  cfg_capacity = 16'd1024;
   logic [THR_W-1:0]  cfg_start = 32'd65536;
   logic [THR_W-1:0]  cfg_min = 32'd0;
   logic [THR_W-1:0]  cfg_max = 32'hFFFF_FFFF;

   threshold_result_type expected_results[$];

   // Stimulus controls and bookkeeping
   bit          src_gaps_on = 1'b0;
   bit          rsp_stalls_on = 1'b0;
   int unsigned hold_requests = 0;
   logic [CAP_W-1:0] last_capacity = 16'd1024;
   int unsigned mismatch_count = 0;
   int unsigned request_total = 0;
   int unsigned restart_total = 0;
   int unsigned rising_total = 0;
   int unsigned write_total = 0;
   int unsigned settings_total = 0;

   // Build tanh(4*i/depth) in Q16 by repeated addition of one step in Q30
   function automatic void build_tanh_table();
      longint unsigned step;
      longint unsigned s2;
      longint unsigned s3;
      longint unsigned s5;
      longint unsigned s7;
      longint unsigned step_tanh;
      longint unsigned acc;
      int              i;
      step      = (64'd1 << 32) / TANH_DEPTH;
      s2        = (step * step) >> 30;
      s3        = (s2 * step) >> 30;
      s5        = (s3 * s2) >> 30;
      s7        = (s5 * s2) >> 30;
      step_tanh = step - s3 / 3 + (2 * s5) / 15 - (17 * s7) / 315;
      acc       = 0;
      for (i = 0; i <= TANH_DEPTH; i++) begin
         tanh_q16[i] = (acc + 64'd8192) >> 14;
         acc = ((acc + step_tanh) << 30) / ((64'd1 << 30) + ((acc * step_tanh) >> 30));
      end
   endfunction

   // Interpolate tanh(trend/10) from the table; trend in Q7.16 percent
   function automatic longint unsigned tanh_of_trend(longint unsigned trend);
      longint unsigned pos;
      longint unsigned frac;
      longint unsigned a;
      longint unsigned b;
      int              idx;
      pos  = (trend * TANH_DEPTH) / 40;
      frac = pos & 64'hFFFF;
      if ((pos >> 16) >= TANH_DEPTH) return tanh_q16[TANH_DEPTH];
      idx = int'(pos >> 16);
      a   = tanh_q16[idx];
      b   = tanh_q16[idx + 1];
      if (b >= a) return a + (((b - a) * frac) >> 16);
      return a - (((a - b) * frac) >> 16);
   endfunction

   // Advance the moving average and threshold by one request, return the expected result
   function automatic threshold_result_type advance_threshold(op_type op,
                                                              logic [CNT_W-1:0] count);
      threshold_result_type r;
      longint unsigned   cap;
      longint unsigned   occ;
      longint unsigned   old_avg;
      longint unsigned   new_avg;
      longint unsigned   factor;
      longint unsigned   thr;
      longint unsigned   tv;
      bit                rising;
      rising = 1'b0;
      if (op == OP_RESTART) begin
         thr_state = cfg_start;
         avg_state = '0;
         r.threshold_value   = cfg_start;
         r.average_occupancy = '0;
         r.pressure_rising   = 1'b0;
         return r;
      end
      cap = (cfg_capacity == 0) ? 1 : longint'(cfg_capacity);
      occ = (longint'(count) * 100 * PCT_UNIT) / cap;
      if (occ > 100 * PCT_UNIT) occ = 100 * PCT_UNIT;
      old_avg = avg_state;
      new_avg = (occ + 9 * old_avg + 5) / 10;
      // trend picks the base factor
      if (new_avg > old_avg) begin
         rising = 1'b1;
         tv = tanh_of_trend(new_avg - old_avg);
         if (new_avg > 70 * PCT_UNIT) factor = PCT_UNIT + (2 * tv + 5) / 10;
         else factor = PCT_UNIT + (tv + 5) / 10;
      end else if (new_avg < old_avg) begin
         factor = 58982;
      end else begin
         factor = PCT_UNIT;
      end
      // boost at high average
      if (new_avg > 95 * PCT_UNIT) factor = (13 * factor + 5) / 10;
      else if (new_avg > 85 * PCT_UNIT) factor = (12 * factor + 5) / 10;
      // scale, then clamp to max and min; min wins when they cross
      thr = (longint'(thr_state) * factor + 32768) >> 16;
      if (thr > cfg_max) thr = cfg_max;
      if (thr < cfg_min) thr = cfg_min;
      thr_state = thr[THR_W-1:0];
      avg_state = new_avg[AVG_W-1:0];
      r.threshold_value   = thr_state;
      r.average_occupancy = avg_state;
      r.pressure_rising   = rising;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   // Most idle stretches short, a few long
   function automatic int unsigned idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
      return $urandom_range(1, 3);
   endfunction

   // Observe all three channels: check results, track registers, predict requests
   always @(posedge clock) begin : channel_monitor
      threshold_result_type got;
      threshold_result_type want;
      if (reset) begin
         avg_state    <= '0;
         thr_state    <= THR_RESET;
         cfg_capacity <= CAP_RESET;
         cfg_start    <= START_RESET;
         cfg_min      <= MIN_RESET;
         cfg_max      <= MAX_RESET;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.threshold_value   = rsp_if.threshold_value;
            got.average_occupancy = rsp_if.average_occupancy;
            got.pressure_rising   = rsp_if.pressure_rising;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with no request pending: thr %h avg %h rise %b",
                  got.threshold_value, got.average_occupancy, got.pressure_rising));
            end else begin
               want = expected_results.pop_front();
               if (want.pressure_rising) rising_total++;
               if (got.threshold_value !== want.threshold_value)
                  report_mismatch($sformatf("threshold_value got %h expected %h",
                     got.threshold_value, want.threshold_value));
               if (got.average_occupancy !== want.average_occupancy)
                  report_mismatch($sformatf("average_occupancy got %h expected %h",
                     got.average_occupancy, want.average_occupancy));
               if (got.pressure_rising !== want.pressure_rising)
                  report_mismatch($sformatf("pressure_rising got %b expected %b",
                     got.pressure_rising, want.pressure_rising));
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            write_total++;
            case (csr_index_type'(csr_if.index))
               CSR_STORE_CAPACITY:  cfg_capacity = csr_if.data[CAP_W-1:0];
               CSR_START_THRESHOLD: cfg_start    = csr_if.data;
               CSR_MIN_THRESHOLD:   cfg_min      = csr_if.data;
               CSR_MAX_THRESHOLD:   cfg_max      = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            request_total++;
            if (req_if.operation == OP_RESTART) restart_total++;
            want = advance_threshold(op_type'(req_if.operation), req_if.entry_count);
            expected_results.push_back(want);
         end
      end
   end

   // Response side: random stalls, plus a long hold-off when a test asks for one
   initial begin : response_sink
      int unsigned stall_left;
      int unsigned hold_left;
      int unsigned holds_done;
      stall_left = 0;
      hold_left  = 0;
      holds_done = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            hold_left  = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 3) == 0) stall_left = idle_length();
         end
      end
   end

   // Abort when no handshake of any kind happens for too long
   always @(posedge clock) begin : watchdog
      int unsigned quiet_cycles;
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] Timeout: no handshake for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, expected_results.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Offer one request; return at the edge that accepts it with valid still high
   task automatic send_request(op_type op, logic [CNT_W-1:0] count);
      int unsigned gap;
      gap = (src_gaps_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.operation   <= op;
      req_if.entry_count <= count;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Drop valid and wait for every outstanding result, then let the block settle
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   // Write all four registers on an idle block
   task automatic apply_settings(logic [CAP_W-1:0] capacity, logic [THR_W-1:0] start,
                                 logic [THR_W-1:0] lo, logic [THR_W-1:0] hi);
      drain_results();
      write_register(CSR_STORE_CAPACITY, {16'd0, capacity});
      write_register(CSR_START_THRESHOLD, start);
      write_register(CSR_MIN_THRESHOLD, lo);
      write_register(CSR_MAX_THRESHOLD, hi);
      csr_if.valid <= 1'b0;
      last_capacity = capacity;
      settings_total++;
   endtask

   // Reset defaults: flat start, full store, overfull count, falling trend, restarts
   task automatic test_default_settings();
      src_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      send_request(OP_UPDATE, 16'd0);
      send_request(OP_UPDATE, 16'd1024);
      send_request(OP_UPDATE, 16'hFFFF);
      send_request(OP_UPDATE, 16'd512);
      send_request(OP_UPDATE, 16'd0);
      send_request(OP_UPDATE, 16'd1);
      send_request(OP_RESTART, 16'hFFFF);
      send_request(OP_UPDATE, 16'd1024);
      send_request(OP_UPDATE, 16'd1024);
      send_request(OP_RESTART, 16'd0);
   endtask

   // Register extremes: capacity one and zero, full-scale thresholds, crossed clamps
   task automatic test_register_extremes();
      apply_settings(16'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_RESTART, 16'd0);
      send_request(OP_UPDATE, 16'd1);
      send_request(OP_UPDATE, 16'd0);
      send_request(OP_UPDATE, 16'hFFFF);
      apply_settings(16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_RESTART, 16'd5);
      send_request(OP_UPDATE, 16'd0);
      send_request(OP_UPDATE, 16'd1);
      send_request(OP_UPDATE, 16'hFFFF);
      // restart loads start unclamped, then min overrides max
      apply_settings(16'hFFFF, 32'h0010_0000, 32'h0002_0000, 32'h0001_0000);
      send_request(OP_RESTART, 16'd0);
      send_request(OP_UPDATE, 16'hFFFF);
      send_request(OP_UPDATE, 16'd0);
   endtask

   // Drive the average past 70, 85 and 95 percent, then let it decay
   task automatic test_high_average();
      int n;
      apply_settings(16'd4096, 32'h0001_0000, 32'h0000_4000, 32'h0040_0000);
      src_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      send_request(OP_RESTART, 16'd0);
      for (n = 0; n < 45; n++) send_request(OP_UPDATE, 16'($urandom_range(3900, 6000)));
      for (n = 0; n < 20; n++) send_request(OP_UPDATE, 16'($urandom_range(0, 800)));
   endtask

   // Hold the response side off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      int n;
      drain_results();
      src_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      hold_requests++;
      for (n = 0; n < 12; n++) send_request(OP_UPDATE, 16'($urandom_range(0, 5000)));
   endtask

   task automatic apply_random_settings();
      logic [CAP_W-1:0] cap;
      logic [THR_W-1:0] start;
      logic [THR_W-1:0] lo;
      logic [THR_W-1:0] hi;
      case ($urandom_range(0, 9))
         0: cap = 16'd0;
         1: cap = 16'd1;
         2: cap = 16'hFFFF;
         3: cap = 16'($urandom());
         default: cap = 16'($urandom_range(16, 4096));
      endcase
      if ($urandom_range(0, 4) == 0) start = $urandom();
      else start = $urandom_range(32'h0000_4000, 32'h0040_0000);
      case ($urandom_range(0, 6))
         0: begin
            lo = 32'd0;
            hi = 32'hFFFF_FFFF;
         end
         1: begin
            hi = $urandom_range(0, 32'h0010_0000);
            lo = $urandom_range(hi, 32'h0020_0000);
         end
         2: begin
            lo = $urandom();
            hi = $urandom();
         end
         default: begin
            lo = $urandom_range(0, 32'h0000_8000);
            hi = $urandom_range(32'h0002_0000, 32'h1000_0000);
         end
      endcase
      apply_settings(cap, start, lo, hi);
   endtask

   // Random settings per phase; counts follow runs around a random occupancy level
   task automatic test_random_phases(int phases, int per_phase);
      int p;
      int n;
      int run_left;
      int level;
      int cap_eff;
      int spread;
      int target;
      int pick;
      for (p = 0; p < phases; p++) begin
         apply_random_settings();
         src_gaps_on   = (p % 4 == 1) || (p % 4 == 3);
         rsp_stalls_on = (p % 4 == 2) || (p % 4 == 3);
         cap_eff  = (last_capacity == 0) ? 1 : int'(last_capacity);
         spread   = cap_eff / 20;
         run_left = 0;
         level    = 0;
         for (n = 0; n < per_phase; n++) begin
            if (run_left == 0) begin
               run_left = $urandom_range(4, 40);
               level    = $urandom_range(0, 115);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               send_request(OP_RESTART, 16'($urandom()));
            end else if (pick < 12) begin
               send_request(OP_UPDATE, 16'($urandom()));
            end else begin
               target = cap_eff * level / 100 + int'($urandom_range(0, 2 * spread)) - spread;
               if (target < 0) target = 0;
               if (target > 65535) target = 65535;
               send_request(OP_UPDATE, 16'(target));
            end
         end
      end
   endtask

   initial begin
      req_if.valid       <= 1'b0;
      req_if.operation   <= OP_UPDATE;
      req_if.entry_count <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= CSR_STORE_CAPACITY;
      csr_if.data        <= '0;
      build_tanh_table();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_settings();
      test_register_extremes();
      test_high_average();
      test_backpressure();
      test_random_phases(14, 133);

      drain_results();
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));
      $display("Covered %0d requests (%0d restarts) over %0d register settings, %0d writes.",
         request_total, restart_total, settings_total, write_total);
      $display("Rising-pressure results: %0d; mismatches: %0d.", rising_total, mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ ema_occupancy_threshold_adjust.f @@
design/ema_ot_pkg.sv
design/ema_ot_if.sv
design/ema_ot_div.sv
design/ema_ot_mul.sv
design/ema_occupancy_threshold_adjust.sv
design/ema_ot_checker.sv
dv/tb_ema_occupancy_threshold_adjust.sv
